>>> sv/hsl_to_rgb_converter_macros.svh
// ----------------------------------------------------------------------------
// HSL to RGB converter assertion macros
// Shared concurrent assertion forms for the converter pipeline.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define HSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hsl_to_rgb_converter: implication failed");

// next-cycle implication, checked out of reset
`define HSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hsl_to_rgb_converter: next-cycle check failed");

`endif

>>> sv/hsl_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Transfer payloads, stage payloads, sector codes and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsl_pkg;

	localparam logic [8:0]  FRAC_ONE    = 9'd256;
	localparam logic [14:0] HUE_FULL    = 15'd23040;
	localparam logic [14:0] HUE_SECTOR  = 15'd3840;
	localparam logic [14:0] HUE_PAIR    = 15'd7680;
	localparam logic [27:0] LIG_SCALE   = 28'd983040;
	localparam logic [27:0] CHROMA_FULL = 28'd3840;
	localparam logic [27:0] CHROMA_HALF = 28'd1920;

	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	typedef struct packed {
		logic [14:0] hue;
		logic [8:0]  saturation;
		logic [8:0]  lightness;
	} hsl_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [8:0]  lightness;
		logic [8:0]  saturation;
		logic [8:0]  span;
		logic [11:0] frac;
		sector_t     sector;
	} prep_t;

	typedef struct packed {
		logic [27:0] cc;
		logic [27:0] xx;
		logic [27:0] mm;
		sector_t     sector;
	} comp_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} product_en_t;

	function automatic logic [7:0] scale_channel(logic [27:0] num);
		logic [31:0] prod;
		prod = {num, 4'b0000} + 32'(num);
		return prod[31:24];
	endfunction

endpackage

>>> sv/hsl_prep.sv
// ----------------------------------------------------------------------------
// HSL prepare stage
// Clamps the fractions, wraps the hue, and forms chroma span, sector and
// secondary fraction; registers them as stage one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_prep import hsl_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  hsl_t  hsl,
	output prep_t prep_s1
);

	logic [8:0]  sat_c;
	logic [8:0]  lig_c;
	logic [14:0] hue_w;
	logic [9:0]  two_l;
	logic [9:0]  lig_gap;
	logic [14:0] base;
	logic [12:0] hm;
	logic [11:0] hdist;
	sector_t     sector;
	prep_t       prep;

	always_comb begin
		sat_c = (hsl.saturation > FRAC_ONE) ? FRAC_ONE : hsl.saturation;
		lig_c = (hsl.lightness > FRAC_ONE) ? FRAC_ONE : hsl.lightness;
		hue_w = (hsl.hue >= HUE_FULL) ? (hsl.hue - HUE_FULL) : hsl.hue;
		two_l = {lig_c, 1'b0};
		lig_gap = (two_l >= 10'(FRAC_ONE)) ? (two_l - 10'(FRAC_ONE))
			: (10'(FRAC_ONE) - two_l);

		if (hue_w < HUE_SECTOR) begin
			sector = SEC_RY;
		end else if (hue_w < HUE_PAIR) begin
			sector = SEC_YG;
		end else if (hue_w < 15'(HUE_PAIR + HUE_SECTOR)) begin
			sector = SEC_GC;
		end else if (hue_w < 15'(2 * HUE_PAIR)) begin
			sector = SEC_CB;
		end else if (hue_w < 15'(2 * HUE_PAIR + HUE_SECTOR)) begin
			sector = SEC_BM;
		end else begin
			sector = SEC_MR;
		end

		if (hue_w < HUE_PAIR) begin
			base = '0;
		end else if (hue_w < 15'(2 * HUE_PAIR)) begin
			base = HUE_PAIR;
		end else begin
			base = 15'(2 * HUE_PAIR);
		end
		hm = 13'(hue_w - base);
		hdist = (hm >= 13'(HUE_SECTOR)) ? 12'(hm - 13'(HUE_SECTOR))
			: 12'(13'(HUE_SECTOR) - hm);

		prep.lightness  = lig_c;
		prep.saturation = sat_c;
		prep.span       = 9'(10'(FRAC_ONE) - lig_gap);
		prep.frac       = 12'(HUE_SECTOR) - hdist;
		prep.sector     = sector;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s1 <= prep;
		end
	end

endmodule

>>> sv/hsl_product.sv
// ----------------------------------------------------------------------------
// HSL product stages
// Stage two forms chroma; stage three forms the chroma, secondary and offset
// terms over the common denominator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_product import hsl_pkg::*; (
	input  logic        clk,
	input  product_en_t en,
	input  prep_t       prep_s1,
	output comp_t       comp_s3
);

	logic [16:0] chroma_s2;
	logic [8:0]  lig_s2;
	logic [11:0] frac_s2;
	sector_t     sector_s2;
	logic [16:0] chroma_full;
	comp_t       comp;

	assign chroma_full = prep_s1.span * prep_s1.saturation;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			chroma_s2 <= chroma_full;
			lig_s2    <= prep_s1.lightness;
			frac_s2   <= prep_s1.frac;
			sector_s2 <= prep_s1.sector;
		end
	end

	always_comb begin
		comp.cc     = 28'(chroma_s2) * CHROMA_FULL;
		comp.xx     = 28'(chroma_s2) * 28'(frac_s2);
		comp.mm     = 28'(lig_s2) * LIG_SCALE - 28'(chroma_s2) * CHROMA_HALF;
		comp.sector = sector_s2;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			comp_s3 <= comp;
		end
	end

endmodule

>>> sv/hsl_mix.sv
// ----------------------------------------------------------------------------
// HSL mix stage
// Places chroma and secondary by sector, adds the offset and scales each
// channel by 255 over the denominator into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_mix import hsl_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  comp_t comp_s3,
	output rgb_t  rgb_s4
);

	logic [27:0] r_num;
	logic [27:0] g_num;
	logic [27:0] b_num;
	rgb_t        rgb;

	always_comb begin
		case (comp_s3.sector)
			SEC_RY: begin
				r_num = comp_s3.cc;
				g_num = comp_s3.xx;
				b_num = '0;
			end
			SEC_YG: begin
				r_num = comp_s3.xx;
				g_num = comp_s3.cc;
				b_num = '0;
			end
			SEC_GC: begin
				r_num = '0;
				g_num = comp_s3.cc;
				b_num = comp_s3.xx;
			end
			SEC_CB: begin
				r_num = '0;
				g_num = comp_s3.xx;
				b_num = comp_s3.cc;
			end
			SEC_BM: begin
				r_num = comp_s3.xx;
				g_num = '0;
				b_num = comp_s3.cc;
			end
			default: begin
				r_num = comp_s3.cc;
				g_num = '0;
				b_num = comp_s3.xx;
			end
		endcase
		rgb.red   = scale_channel(r_num + comp_s3.mm);
		rgb.green = scale_channel(g_num + comp_s3.mm);
		rgb.blue  = scale_channel(b_num + comp_s3.mm);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s4 <= rgb;
		end
	end

endmodule

>>> sv/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Four-stage pipeline from a Q9.6 hue and Q1.8 saturation and lightness to
// an 8-bit red, green and blue triple.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel hsl_valid / hsl_stall / hsl carries one pixel per transfer.
//   Output channel rgb_valid / rgb_stall / rgb carries one color per transfer.
//   A transfer happens at a rising edge with valid high and stall low.
//   A pixel taken moves through prep_s1, chroma_s2, comp_s3 and rgb_s4 to rgb.
//   Throughput: one pixel per cycle while rgb_stall is low; each of the four
//   register stages (prepare, chroma multiply, term multiply, mix and scale)
//   takes a new pixel every cycle unless a stall holds it.
//   Every stage holds its own valid bit; a stage loads when it is empty or
//   when the stage after it advances, so bubbles close up.
//   While rgb_stall is high a full output register holds; hsl_stall rises only
//   when all four stages hold a pixel.
//   Reset (arst_n low) clears every valid bit at once; no pixel is kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_macros.svh"

module hsl_to_rgb_converter import hsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic hsl_valid,
	output logic hsl_stall,
	input  hsl_t hsl,
	output logic rgb_valid,
	input  logic rgb_stall,
	output rgb_t rgb
);

	logic        valid_s1;
	logic        valid_s2;
	logic        valid_s3;
	logic        valid_s4;
	logic        ready_s1;
	logic        ready_s2;
	logic        ready_s3;
	logic        ready_s4;
	prep_t       prep_s1;
	comp_t       comp_s3;
	rgb_t        rgb_s4;
	product_en_t product_en;

	assign ready_s4 = !valid_s4 || !rgb_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;

	assign product_en.s2 = ready_s2 && valid_s1;
	assign product_en.s3 = ready_s3 && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= hsl_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	hsl_prep u_prep (
		.clk     (clk),
		.en      (ready_s1 && hsl_valid),
		.hsl     (hsl),
		.prep_s1 (prep_s1)
	);

	hsl_product u_product (
		.clk     (clk),
		.en      (product_en),
		.prep_s1 (prep_s1),
		.comp_s3 (comp_s3)
	);

	hsl_mix u_mix (
		.clk     (clk),
		.en      (ready_s4 && valid_s3),
		.comp_s3 (comp_s3),
		.rgb_s4  (rgb_s4)
	);

	assign hsl_stall = !ready_s1;
	assign rgb_valid = valid_s4;
	assign rgb       = rgb_s4;

	`HSL_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, hsl_valid && !hsl_stall, valid_s1)
	`HSL_ASSERT_NEXT(a_blocked_s2_holds, clk, arst_n, valid_s2 && !ready_s3, valid_s2)
	`HSL_ASSERT_IMPLY(a_stall_when_full, clk, arst_n, hsl_stall,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && rgb_stall)
	`HSL_ASSERT_NEXT(a_out_moves_on_s3, clk, arst_n, valid_s3 && !(valid_s4 && rgb_stall), rgb_valid)

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Drives pixels through the valid/stall input channel and checks every color
// out against the table on typed rows, else a fixed-point model in the bench.
// A directed table covers black, white, gray, the six primary and secondary
// hues, hue wrap, and clamping of saturation and lightness. About 500 random
// pixels follow, most in range and some out of range or on sector edges.
// Both channels idle in random bursts, with a quiet stretch at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import hsl_pkg::*;

	localparam longint unsigned COLOR_DENOM = 64'd251658240;
	localparam int RANDOM_PIXELS = 500;
	localparam int QUIET_PIXELS = 100;
	localparam int DRAIN_PIXEL = 200;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		hsl_t px;
		logic typed;
		rgb_t want;
	} pixel_row_t;

	localparam int DIRECTED_ROWS = 23;

	pixel_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{'{15'd0,     9'd0,   9'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
		'{'{15'd23039, 9'd256, 9'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
		'{'{15'd0,     9'd256, 9'd256}, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{'{15'd11520, 9'd0,   9'd256}, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{'{15'd32767, 9'd511, 9'd511}, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{'{15'd5000,  9'd0,   9'd128}, 1'b1, '{8'd127, 8'd127, 8'd127}},
		'{'{15'd0,     9'd256, 9'd128}, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{'{15'd3840,  9'd256, 9'd128}, 1'b1, '{8'd255, 8'd255, 8'd0}},
		'{'{15'd7680,  9'd256, 9'd128}, 1'b1, '{8'd0,   8'd255, 8'd0}},
		'{'{15'd11520, 9'd256, 9'd128}, 1'b1, '{8'd0,   8'd255, 8'd255}},
		'{'{15'd15360, 9'd256, 9'd128}, 1'b1, '{8'd0,   8'd0,   8'd255}},
		'{'{15'd19200, 9'd256, 9'd128}, 1'b1, '{8'd255, 8'd0,   8'd255}},
		'{'{15'd23040, 9'd256, 9'd128}, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{'{15'd26880, 9'd256, 9'd128}, 1'b1, '{8'd255, 8'd255, 8'd0}},
		'{'{15'd12000, 9'd128, 9'd300}, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{'{15'd3839,  9'd256, 9'd128}, 1'b0, '0},
		'{'{15'd23039, 9'd200, 9'd100}, 1'b0, '0},
		'{'{15'd5000,  9'd300, 9'd128}, 1'b0, '0},
		'{'{15'd19199, 9'd256, 9'd64},  1'b0, '0},
		'{'{15'd9000,  9'd1,   9'd1},   1'b0, '0},
		'{'{15'd21000, 9'd255, 9'd255}, 1'b0, '0},
		'{'{15'd16384, 9'd170, 9'd85},  1'b0, '0},
		'{'{15'd32767, 9'd256, 9'd128}, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic hsl_valid;
	logic hsl_stall;
	hsl_t hsl;
	logic rgb_valid;
	logic rgb_stall;
	rgb_t rgb;

	logic row_typed;
	rgb_t row_want;
	bit quiet;
	int mismatch_count;
	rgb_t pending_colors [$];

	hsl_to_rgb_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.hsl_valid(hsl_valid),
		.hsl_stall(hsl_stall),
		.hsl(hsl),
		.rgb_valid(rgb_valid),
		.rgb_stall(rgb_stall),
		.rgb(rgb)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] scale_to_byte(longint unsigned num);
		return 8'((num * 64'd255) / COLOR_DENOM);
	endfunction

	function automatic rgb_t hsl_to_rgb_model(hsl_t p);
		longint unsigned h, s, l, two_l, lig_gap, chroma, hm, hdist, f;
		longint unsigned cc, xx, mm, comp_r, comp_g, comp_b;
		sector_t sec;
		rgb_t c;
		h = p.hue;
		s = p.saturation;
		l = p.lightness;
		if (s > FRAC_ONE) s = FRAC_ONE;
		if (l > FRAC_ONE) l = FRAC_ONE;
		if (h >= HUE_FULL) h = h - HUE_FULL;
		two_l = 2 * l;
		lig_gap = (two_l >= FRAC_ONE) ? two_l - FRAC_ONE : FRAC_ONE - two_l;
		chroma = (FRAC_ONE - lig_gap) * s;
		hm = h % HUE_PAIR;
		hdist = (hm >= HUE_SECTOR) ? hm - HUE_SECTOR : HUE_SECTOR - hm;
		f = HUE_SECTOR - hdist;
		cc = chroma * CHROMA_FULL;
		xx = chroma * f;
		mm = l * LIG_SCALE - chroma * CHROMA_HALF;
		sec = sector_t'(3'(h / HUE_SECTOR));
		case (sec)
			SEC_RY: begin comp_r = cc; comp_g = xx; comp_b = 0;  end
			SEC_YG: begin comp_r = xx; comp_g = cc; comp_b = 0;  end
			SEC_GC: begin comp_r = 0;  comp_g = cc; comp_b = xx; end
			SEC_CB: begin comp_r = 0;  comp_g = xx; comp_b = cc; end
			SEC_BM: begin comp_r = xx; comp_g = 0;  comp_b = cc; end
			default: begin comp_r = cc; comp_g = 0; comp_b = xx; end
		endcase
		c.red = scale_to_byte(comp_r + mm);
		c.green = scale_to_byte(comp_g + mm);
		c.blue = scale_to_byte(comp_b + mm);
		return c;
	endfunction

	function automatic logic [8:0] random_fraction();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return 9'($urandom_range(257, 511));
		if (pick == 1) return ($urandom_range(0, 1) == 0) ? 9'd0 : FRAC_ONE;
		return 9'($urandom_range(0, 256));
	endfunction

	function automatic hsl_t random_pixel();
		hsl_t p;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			p.hue = 15'($urandom_range(23040, 32767));
		else if (pick == 1)
			p.hue = 15'($urandom_range(1, 6) * 3840 - 1 + $urandom_range(0, 2));
		else
			p.hue = 15'($urandom_range(0, 23039));
		p.saturation = random_fraction();
		p.lightness = random_fraction();
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
	endtask

	task automatic send_pixel(input hsl_t px, input logic typed, input rgb_t want);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
		if (gap != 0) begin
			@(negedge clk);
			hsl_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		hsl_valid <= 1'b1;
		hsl <= px;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (hsl_stall) @(posedge clk);
	endtask

	task automatic drain_colors();
		@(negedge clk);
		hsl_valid <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
	endtask

	// push the expected color of each transfer in
	always @(posedge clk) begin
		if (arst_n === 1'b1 && hsl_valid === 1'b1 && hsl_stall === 1'b0)
			pending_colors.push_back(row_typed ? row_want : hsl_to_rgb_model(hsl));
	end

	// check each transfer out against the oldest expected color
	always @(posedge clk) begin
		rgb_t want;
		if (arst_n === 1'b1 && rgb_valid === 1'b1 && rgb_stall === 1'b0) begin
			if (pending_colors.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected color %h", $realtime, rgb);
			end else begin
				want = pending_colors.pop_front();
				if (rgb.red !== want.red) report_mismatch("red", want.red, rgb.red);
				if (rgb.green !== want.green) report_mismatch("green", want.green, rgb.green);
				if (rgb.blue !== want.blue) report_mismatch("blue", want.blue, rgb.blue);
			end
		end
	end

	initial begin
		rgb_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				rgb_stall <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				rgb_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				rgb_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		hsl_valid = 1'b0;
		hsl = '0;
		row_typed = 1'b0;
		row_want = '0;
		quiet = 1'b0;
		mismatch_count = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if (i == DRAIN_PIXEL) drain_colors();
			if (i == RANDOM_PIXELS - QUIET_PIXELS) quiet = 1'b1;
			send_pixel(random_pixel(), 1'b0, '0);
		end
		drain_colors();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

>>> hsl_to_rgb_converter.f
+incdir+sv
sv/hsl_pkg.sv
sv/hsl_prep.sv
sv/hsl_product.sv
sv/hsl_mix.sv
sv/hsl_to_rgb_converter.sv
bench/tb.sv
